[design/tempo_locked_phasor_assert.svh]
// Assertion macros for the port checker of the tempo-locked phasor.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef TEMPO_LOCKED_PHASOR_ASSERT_SVH
`define TEMPO_LOCKED_PHASOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tempo_locked_phasor check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tempo_locked_phasor check failed");

// Consequent must hold after a delay that follows the antecedent.
`define TLP_ASSERT_TWO(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("tempo_locked_phasor check failed");

`endif

[design/tlp_pkg.sv]
// Shared constants and opcodes for the tempo-locked phasor.
// Used by the top level and by its port checker; no dependencies.
package tlp_pkg;

  localparam int VECTOR_LEN_DEFAULT = 64;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 88;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [55:0] ONE_Q32        = 56'h00_0001_0000_0000;
  localparam logic [55:0] PHASE_INACTIVE = 56'hFF_FFFF_0000_0000;
  localparam logic [32:0] RATE_MAX       = 33'h1_FFFF_FFFF;
  localparam logic [32:0] RATE_ONE       = 33'h1_0000_0000;

endpackage

[design/tempo_locked_phasor.sv]
// Tempo-locked quarter-note phasor: top level with its sequencer and divider.
// Depends on tlp_pkg for opcodes and fixed-point constants.
//
// Usage: requests arrive on the s_ channel, opcode in s_tuser. A set-time
// request latches the host position, tempo, transport flag and sample rate
// and derives the phase and per-sample rate; it produces no result. It holds
// the block in S_SET when inactive or on a fresh start at zero sample rate,
// in S_SET then S_ADJ when a continuing rate needs no division, and in S_SET,
// S_ADJ (continuing only), S_DIV and S_SAT when the bit-serial divider runs
// (56 quotient steps, one 33-bit compare and subtract per cycle). A tick
// request produces VECTOR_LEN results on the m_ channel, one per cycle while
// m_tready is high, with m_tlast on the final one; the first result is
// registered once the output register is free. A clear request is handled
// in the idle state. s_tready is high only while the sequencer is idle; a
// new request may be taken while the final result of a tick still waits in
// the output register. When the receiver stalls, the output register holds
// its result and the sequencer waits. Synchronous reset clears the phasor
// state: phase and rate zero, transport stopped, no result pending.
module tempo_locked_phasor #(
  parameter int VECTOR_LEN = tlp_pkg::VECTOR_LEN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [55:0] beat_position, [81:56] tempo_bpm, [82] is_playing,
  // [101:83] sample_rate_hz, [103:102] zero
  input  logic [tlp_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] opcode
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [55:0] phase, [87:56] samples_since_start
  output logic [tlp_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);

  localparam int CNT_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SET  = 3'd1;
  localparam logic [2:0] S_ADJ  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_TICK = 3'd5;

  logic [2:0] state;

  // Phasor state.
  logic [55:0] phase_acc;
  logic [32:0] phase_rate;
  logic [55:0] prev_position;
  logic [55:0] prev_phase;
  logic        was_playing;
  logic [31:0] samples_since_set;
  logic [31:0] start_count;

  // Latched request fields.
  logic [55:0] pos_r;
  logic [25:0] bpm_r;
  logic        play_r;
  logic [18:0] sr_r;

  // Set-time working registers.
  logic [56:0] diff_r;
  logic        fresh_r;
  logic [31:0] divisor;
  logic [31:0] rem;
  logic [55:0] quo;
  logic [5:0]  div_cnt;

  logic [CNT_W-1:0] vec_cnt;

  // Set-time decode on the latched request.
  logic        active;
  logic        fresh;
  logic        pos_positive;
  logic [55:0] ph;
  logic [56:0] diff;
  logic [24:0] den;

  always_comb begin
    pos_positive = !pos_r[55] && (pos_r != 56'd0);
    active       = (pos_r != prev_position) && play_r;
    fresh        = play_r && !was_playing;
    if (!active) begin
      ph = 56'd0;
    end else if (pos_positive) begin
      ph = {24'd0, pos_r[31:0]};
    end else begin
      ph = pos_r;
    end
    diff = {ph[55], ph} - {prev_phase[55], prev_phase};
    den  = 25'(sr_r) * 25'd60;
  end

  // Wrap of a negative delta and its sign test.
  logic [56:0] dadj;
  logic        dadj_nonpos;

  always_comb begin
    dadj        = diff_r[56] ? (diff_r + {1'b0, tlp_pkg::ONE_Q32}) : diff_r;
    dadj_nonpos = dadj[56] || (dadj == 57'd0);
  end

  // One restoring divide step.
  logic [32:0] trial;
  logic        trial_ge;
  logic [32:0] trial_diff;

  always_comb begin
    trial      = {rem, quo[55]};
    trial_ge   = trial >= {1'b0, divisor};
    trial_diff = trial - {1'b0, divisor};
  end

  // Phase advance for the next sample.
  logic [55:0] acc_sum;
  logic [55:0] acc_next;

  always_comb begin
    acc_sum = phase_acc + {23'd0, phase_rate};
    if ($signed(acc_sum) > $signed(tlp_pkg::ONE_Q32)) begin
      acc_next = acc_sum - tlp_pkg::ONE_Q32;
    end else begin
      acc_next = acc_sum;
    end
  end

  logic out_free;
  logic vec_last;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign vec_last = (vec_cnt == CNT_W'(VECTOR_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      phase_acc         <= 56'd0;
      phase_rate        <= 33'd0;
      prev_position     <= 56'd0;
      prev_phase        <= 56'd0;
      was_playing       <= 1'b0;
      samples_since_set <= 32'd0;
      start_count       <= 32'd0;
      m_tvalid          <= 1'b0;
      vec_cnt           <= '0;
      div_cnt           <= 6'd0;
    end else begin
      // In the tick state an accepted result is replaced by the next one.
      if (m_tvalid && m_tready && (state != S_TICK)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pos_r  <= s_tdata[55:0];
            bpm_r  <= s_tdata[81:56];
            play_r <= s_tdata[82];
            sr_r   <= s_tdata[101:83];
            case (s_tuser)
              tlp_pkg::OP_SET: begin
                state <= S_SET;
              end
              tlp_pkg::OP_TICK: begin
                vec_cnt <= '0;
                state   <= S_TICK;
              end
              tlp_pkg::OP_CLEAR: begin
                phase_rate  <= 33'd0;
                was_playing <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SET: begin
          prev_position     <= pos_r;
          prev_phase        <= ph;
          was_playing       <= play_r;
          samples_since_set <= 32'd0;
          diff_r            <= diff;
          fresh_r           <= fresh;
          rem               <= 32'd0;
          div_cnt           <= 6'd0;
          if (!active) begin
            phase_acc  <= tlp_pkg::PHASE_INACTIVE;
            phase_rate <= 33'd0;
            state      <= S_IDLE;
          end else if (fresh) begin
            start_count <= 32'd0;
            phase_acc   <= 56'd0;
            divisor     <= {7'd0, den};
            quo         <= {14'd0, bpm_r, 16'd0};
            if (den == 25'd0) begin
              phase_rate <= tlp_pkg::RATE_MAX;
              state      <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end else begin
            phase_acc <= ph;
            divisor   <= samples_since_set;
            state     <= S_ADJ;
          end
        end
        S_ADJ: begin
          if (dadj_nonpos) begin
            phase_rate <= 33'd0;
            state      <= S_IDLE;
          end else if (divisor == 32'd0) begin
            phase_rate <= tlp_pkg::RATE_ONE;
            state      <= S_IDLE;
          end else begin
            quo   <= dadj[55:0];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= trial_ge ? trial_diff[31:0] : trial[31:0];
          quo     <= {quo[54:0], trial_ge};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd55) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (fresh_r) begin
            phase_rate <= (quo > {23'd0, tlp_pkg::RATE_MAX}) ? tlp_pkg::RATE_MAX
                                                             : quo[32:0];
          end else begin
            phase_rate <= (quo > {23'd0, tlp_pkg::RATE_ONE}) ? tlp_pkg::RATE_ONE
                                                             : quo[32:0];
          end
          state <= S_IDLE;
        end
        S_TICK: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {start_count + 32'(vec_cnt), phase_acc};
            m_tlast   <= vec_last;
            phase_acc <= acc_next;
            vec_cnt   <= vec_cnt + CNT_W'(1);
            if (vec_last) begin
              samples_since_set <= samples_since_set + 32'(VECTOR_LEN);
              start_count       <= start_count + 32'(VECTOR_LEN);
              state             <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/tlp_checker.sv]
// Port-level checker for the tempo-locked phasor, bound to the top level.
// Depends on tlp_pkg and the assertion macros in tempo_locked_phasor_assert.svh.
`include "tempo_locked_phasor_assert.svh"

module tlp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [tlp_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [1:0]                     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tlp_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  logic tick_req;
  logic in_width_seen;

  assign tick_req      = s_tvalid && s_tready && (s_tuser == tlp_pkg::OP_TICK);
  assign in_width_seen = ^s_tdata || 1'b1;

  // A stalled result holds.
  `TLP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Within a vector the sample count steps by one from result to result.
  `TLP_ASSERT_NEXT(a_count_step, m_tvalid && m_tready && !m_tlast,
                   m_tvalid && (m_tdata[87:56] == $past(m_tdata[87:56]) + 32'd1))

  // No request is taken while a vector is still being produced.
  `TLP_ASSERT_SAME(a_busy_in_vector, m_tvalid && !m_tlast && in_width_seen, !s_tready)

  // A tick taken with the output empty shows its first result once the sequencer has entered S_TICK and registered it.
  `TLP_ASSERT_TWO(a_tick_latency, tick_req && !m_tvalid, m_tvalid)

endmodule

bind tempo_locked_phasor tlp_checker u_tlp_checker (.*);

[tb/tempo_locked_phasor_checker.sv]
`timescale 1ns / 1ps
// Checker for the tempo-locked phasor: watches both stream channels, predicts
// every tick result from its own copy of the phasor state and compares them.
// Depends on tlp_pkg for opcodes, widths and fixed-point constants.
module tempo_locked_phasor_checker #(
  parameter int VEC_LEN = tlp_pkg::VECTOR_LEN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tlp_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [tlp_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            m_tlast,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  typedef struct packed {
    logic [55:0] phase;
    logic [31:0] count;
    logic        last;
  } phasor_result_t;

  localparam longint UNIT = longint'(tlp_pkg::ONE_Q32);

  phasor_result_t expected_phases[$];

  longint      phase_acc;
  longint      prev_pos;
  longint      prev_ph;
  logic [32:0] rate;
  bit          was_active;
  bit          was_playing;
  logic [31:0] since_set;
  logic [31:0] start_cnt;
  int          errors;
  int          results_seen;

  function automatic longint sext56(logic [63:0] v);
    return {{8{v[55]}}, v[55:0]};
  endfunction

  task automatic clear_phasor_state();
    phase_acc = 0;
    rate = '0;
    prev_pos = 0;
    prev_ph = 0;
    was_active = 0;
    was_playing = 0;
    since_set = '0;
    start_cnt = '0;
    expected_phases.delete();
  endtask

  task automatic predict_set_time(longint pos, logic [25:0] bpm, bit playing,
                                  logic [18:0] sr);
    bit          active;
    bit          fresh;
    longint      ph;
    longint      delta;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    active = (pos != prev_pos) && playing;
    fresh = playing && !was_playing;
    ph = 0;
    if (active) begin
      // A positive position keeps only its fraction; zero or negative stays whole.
      ph = (pos > 0) ? (pos & 64'hFFFF_FFFF) : pos;
      phase_acc = ph;
      if (fresh) begin
        den = 64'd60 * sr;
        start_cnt = '0;
        phase_acc = 0;
        if (den == 0) begin
          rate = tlp_pkg::RATE_MAX;
        end else begin
          num = 64'(bpm) << 16;
          quo = num / den;
          rate = (quo > tlp_pkg::RATE_MAX) ? tlp_pkg::RATE_MAX : quo[32:0];
        end
      end else begin
        delta = ph - prev_ph;
        if (delta < 0) delta = delta + UNIT;
        if (delta <= 0) begin
          rate = '0;
        end else if (since_set == 0) begin
          rate = tlp_pkg::RATE_ONE;
        end else begin
          quo = 64'(delta) / 64'(since_set);
          rate = (quo > tlp_pkg::RATE_ONE) ? tlp_pkg::RATE_ONE : quo[32:0];
        end
      end
    end else begin
      phase_acc = sext56(tlp_pkg::PHASE_INACTIVE);
      rate = '0;
    end
    prev_pos = pos;
    prev_ph = ph;
    was_active = active;
    was_playing = playing;
    since_set = '0;
  endtask

  task automatic predict_tick();
    for (int n = 0; n < VEC_LEN; n++) begin
      expected_phases.push_back(phasor_result_t'{phase_acc[55:0], 32'(start_cnt + n),
                                                 n == VEC_LEN - 1});
      phase_acc = sext56(64'(phase_acc + longint'({31'd0, rate})));
      if (phase_acc > UNIT) phase_acc = phase_acc - UNIT;
    end
    since_set = since_set + VEC_LEN;
    start_cnt = start_cnt + VEC_LEN;
  endtask

  task automatic note_failure(string what, phasor_result_t want, phasor_result_t got);
    if (errors < 10)
      $display("%0t: %s: expected phase %h count %h last %b, got phase %h count %h last %b",
               $time, what, want.phase, want.count, want.last,
               got.phase, got.count, got.last);
    errors++;
  endtask

  always @(posedge clk) begin
    phasor_result_t got;
    phasor_result_t want;
    if (rst) begin
      clear_phasor_state();
    end else begin
      if (m_tvalid && m_tready) begin
        got = phasor_result_t'{m_tdata[55:0], m_tdata[87:56], m_tlast};
        results_seen++;
        if (expected_phases.size() == 0) begin
          note_failure("result with nothing pending", '0, got);
        end else begin
          want = expected_phases.pop_front();
          if (got.phase != want.phase || got.count != want.count ||
              got.last != want.last)
            note_failure("result mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          tlp_pkg::OP_SET:   predict_set_time(sext56(64'(s_tdata[55:0])), s_tdata[81:56],
                                              s_tdata[82], s_tdata[101:83]);
          tlp_pkg::OP_TICK:  predict_tick();
          tlp_pkg::OP_CLEAR: begin
            rate = '0;
            was_active = 0;
            was_playing = 0;
          end
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending <= expected_phases.size();
    checked <= results_seen;
  end

endmodule

[tb/tempo_locked_phasor_tb.sv]
`timescale 1ns / 1ps
// Top of the tempo-locked phasor testbench: clock, reset, request stimulus,
// output pacing and the verdict. Depends on tlp_pkg, the block and its checker.
module tempo_locked_phasor_tb;

  localparam int          RANDOM_ITEMS = 96;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [25:0] BPM_120      = 26'd120 << 16;
  localparam longint      POS_MAX      = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint      POS_MIN      = -64'sh0080_0000_0000_0000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [tlp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]                     s_tuser = tlp_pkg::OP_SET;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [tlp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 11;
  int recv_idle_pct = 60;
  bit hold_off = 0;
  bit pressure_go = 0;
  int op_count[4] = '{0, 0, 0, 0};

  always #1 clk = ~clk;

  tempo_locked_phasor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  tempo_locked_phasor_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always @(negedge clk)
    m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);

  // Long output stall: the output register holds a tick result and the block must stall its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint q32(int whole, logic [31:0] frac);
    return (longint'(whole) <<< 32) + longint'({32'd0, frac});
  endfunction

  function automatic logic [18:0] pick_sample_rate();
    case ($urandom_range(0, 5))
      0: return 19'd44100;
      1: return 19'd48000;
      2: return 19'd96000;
      3: return 19'd192000;
      4: return 19'd384000;
      default: return 19'($urandom_range(1, 384000));
    endcase
  endfunction

  // Called right after a falling edge; returns right after the falling edge
  // that follows acceptance of the request.
  task automatic send_request(logic [1:0] op, longint pos = 0, logic [25:0] bpm = '0,
                              bit playing = 0, logic [18:0] sr = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, sr, playing, bpm, pos[55:0]};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    op_count[op]++;
  endtask

  initial begin
    int     counted;
    bit     pressured;
    longint cur_pos;
    logic [25:0] bpm;
    logic [18:0] sr;
    logic [1:0]  op;
    counted = 0;
    pressured = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests.
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, 0, BPM_120, 1, 19'd48000); // position unchanged: inactive
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_CLEAR);
    send_request(tlp_pkg::OP_SET, q32(5, 32'h4000_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, q32(5, 32'h4150_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_TICK);
    // Fraction falls below the previous one, so the phase delta wraps by one beat.
    send_request(tlp_pkg::OP_SET, q32(6, 32'h0100_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_TICK);
    // Back-to-back sets: no samples in between, then a zero phase delta.
    send_request(tlp_pkg::OP_SET, q32(6, 32'h5000_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_SET, q32(7, 32'h5000_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, q32(-4, 32'h8000_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, q32(-4, 32'hC000_0000), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_CLEAR);
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, q32(1, 32'h0), BPM_120, 1, 19'd0); // zero sample rate
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_CLEAR);
    send_request(tlp_pkg::OP_SET, q32(3, 32'h0), 26'h3FF_FFFF, 1, 19'd1); // rate overflow
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_CLEAR);
    send_request(tlp_pkg::OP_SET, q32(4, 32'h0), 26'd0, 1, 19'h7FFFF);
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, q32(9, 32'h0), BPM_120, 0, 19'd48000); // transport stopped
    send_request(tlp_pkg::OP_TICK);
    send_request(tlp_pkg::OP_SET, POS_MAX, BPM_120, 1, 19'd44100);
    send_request(tlp_pkg::OP_SET, POS_MIN, BPM_120, 1, 19'd44100);
    send_request(tlp_pkg::OP_TICK);
    // Huge delta over one vector clamps the rate to one beat per sample.
    send_request(tlp_pkg::OP_SET, q32(1, 32'h8000_0000), BPM_120, 1, 19'd44100);
    send_request(tlp_pkg::OP_TICK);
    send_request(OP_UNUSED, q32(2, 32'h1234_5678), BPM_120, 1, 19'd48000);
    send_request(tlp_pkg::OP_CLEAR);

    // Random part: mostly play sessions, some noise requests.
    while (counted < RANDOM_ITEMS) begin
      if (counted < RANDOM_ITEMS / 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 60;
      end else if (counted < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (!pressured && counted >= 2 * RANDOM_ITEMS / 3) begin
        pressured = 1;
        pressure_go = 1;
        repeat (5) begin
          send_request(tlp_pkg::OP_TICK);
          counted++;
        end
      end else if ($urandom_range(0, 99) < 20) begin
        op = 2'($urandom_range(0, 3));
        send_request(op, longint'({$urandom, $urandom}), 26'($urandom),
                     1'($urandom_range(0, 1)), 19'($urandom));
        if (op != OP_UNUSED) counted++;
      end else begin
        if ($urandom_range(0, 1)) begin
          send_request(tlp_pkg::OP_CLEAR);
          counted++;
        end
        cur_pos = ($urandom_range(0, 3) == 0) ? -q32($urandom_range(0, 500), $urandom)
                                              : q32($urandom_range(0, 1000), $urandom);
        bpm = ($urandom_range(0, 7) == 0) ? 26'($urandom)
                                          : 26'(($urandom_range(40, 300) << 16) |
                                                $urandom_range(0, 65535));
        sr = pick_sample_rate();
        send_request(tlp_pkg::OP_SET, cur_pos, bpm, 1, sr);
        counted++;
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(1, 3)) begin
            send_request(tlp_pkg::OP_TICK);
            counted++;
          end
          cur_pos = cur_pos + longint'($urandom_range(0, 32'h6000_0000));
          send_request(tlp_pkg::OP_SET, cur_pos, bpm, 1, sr);
          counted++;
        end
        send_request(tlp_pkg::OP_TICK);
        counted++;
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d set-time, %0d tick, %0d clear and %0d unused-opcode requests.",
             op_count[tlp_pkg::OP_SET], op_count[tlp_pkg::OP_TICK],
             op_count[tlp_pkg::OP_CLEAR], op_count[OP_UNUSED]);
    $display("%0d phase results checked under three pacing mixes and one long output stall.",
             checked);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[tempo_locked_phasor.f]
+incdir+design
design/tlp_pkg.sv
design/tempo_locked_phasor.sv
design/tlp_checker.sv
tb/tempo_locked_phasor_checker.sv
tb/tempo_locked_phasor_tb.sv
